// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. Each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TWS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TWS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tws_pkg.sv -----
// ----------------------------------------------------------------------------
// tws_pkg
// Shared widths, phase codes and the per-tick result record.
// ----------------------------------------------------------------------------
package tws_pkg;

	localparam int DELAY_W = 10;
	localparam int CFG_W   = 10;

	// Request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Sequencer phases
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_ENABLE  = 3'd1;
	localparam logic [2:0] PH_CMD     = 3'd2;
	localparam logic [2:0] PH_WDATA   = 3'd3;
	localparam logic [2:0] PH_RELEASE = 3'd4;
	localparam logic [2:0] PH_READ    = 3'd5;
	localparam logic [2:0] PH_DISABLE = 3'd6;

	// Bit steps within one serial bit
	localparam logic [1:0] STEP_SETUP = 2'd0;
	localparam logic [1:0] STEP_HIGH  = 2'd1;
	localparam logic [1:0] STEP_LOW   = 2'd2;

	// Result of one tick
	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       data_out;
		logic       data_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       request_ignored;
	} res_t;

endpackage

// ----- rtl/tws_seq.sv -----
// ----------------------------------------------------------------------------
// tws_seq
// Pin sequencer: holds the transaction state and advances it one tick per
// accepted input, producing that tick's pin levels and status.
// ----------------------------------------------------------------------------
module tws_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [1:0]                 req_type,
	input  logic [7:0]                 command,
	input  logic [7:0]                 write_data,
	input  logic                       data_pin_in,
	input  logic [tws_pkg::DELAY_W-1:0] ticks,
	output tws_pkg::res_t              res
);

	logic [2:0]                  phase_q, phase_d;
	logic [1:0]                  step_q, step_d;
	logic [2:0]                  idx_q, idx_d;
	logic [tws_pkg::DELAY_W-1:0] dly_q, dly_d;
	logic [7:0]                  cmd_q, cmd_d;
	logic [7:0]                  wdat_q, wdat_d;
	logic [7:0]                  acc_q, acc_d;
	logic                        rmode_q, rmode_d;
	logic                        ce_q, ce_d;
	logic                        sclk_q, sclk_d;
	logic                        dout_q, dout_d;
	logic                        drv_q, drv_d;
	logic                        request;
	logic [tws_pkg::DELAY_W-1:0] hold;

	assign request = (req_type == tws_pkg::REQ_WRITE) || (req_type == tws_pkg::REQ_READ);
	// One delay unit; zero acts as one
	assign hold = (ticks == '0) ? '0 : ticks - 1'b1;

	// Next state for one tick
	always_comb begin
		phase_d = phase_q;
		step_d  = step_q;
		idx_d   = idx_q;
		dly_d   = dly_q;
		cmd_d   = cmd_q;
		wdat_d  = wdat_q;
		acc_d   = acc_q;
		rmode_d = rmode_q;
		ce_d    = ce_q;
		sclk_d  = sclk_q;
		dout_d  = dout_q;
		drv_d   = drv_q;
		res     = '0;
		if (phase_q == tws_pkg::PH_IDLE) begin
			if (request) begin
				cmd_d   = command;
				wdat_d  = write_data;
				rmode_d = (req_type == tws_pkg::REQ_READ);
				acc_d   = '0;
				idx_d   = '0;
				step_d  = tws_pkg::STEP_SETUP;
				ce_d    = 1'b1;
				phase_d = tws_pkg::PH_ENABLE;
				dly_d   = hold;
				res.busy_res = 1'b1;
			end
		end else begin
			res.busy_res        = 1'b1;
			res.request_ignored = request;
			if (dly_q != '0) begin
				dly_d = dly_q - 1'b1;
			end else begin
				dly_d = hold;
				case (phase_q)
					tws_pkg::PH_ENABLE: begin
						phase_d = tws_pkg::PH_CMD;
						idx_d   = '0;
						drv_d   = 1'b1;
						dout_d  = cmd_q[0];
						step_d  = tws_pkg::STEP_SETUP;
					end
					tws_pkg::PH_CMD, tws_pkg::PH_WDATA: begin
						if (step_q == tws_pkg::STEP_SETUP) begin
							sclk_d = 1'b1;
							step_d = tws_pkg::STEP_HIGH;
						end else if (step_q == tws_pkg::STEP_HIGH) begin
							sclk_d = 1'b0;
							step_d = tws_pkg::STEP_LOW;
						end else if (idx_q != 3'd7) begin
							idx_d  = idx_q + 3'd1;
							drv_d  = 1'b1;
							dout_d = (phase_q == tws_pkg::PH_CMD) ? cmd_q[idx_d] : wdat_q[idx_d];
							step_d = tws_pkg::STEP_SETUP;
						end else if (phase_q == tws_pkg::PH_WDATA) begin
							ce_d    = 1'b0;
							phase_d = tws_pkg::PH_DISABLE;
						end else if (rmode_q) begin
							drv_d   = 1'b0;
							dout_d  = 1'b0;
							phase_d = tws_pkg::PH_RELEASE;
						end else begin
							phase_d = tws_pkg::PH_WDATA;
							idx_d   = '0;
							drv_d   = 1'b1;
							dout_d  = wdat_q[0];
							step_d  = tws_pkg::STEP_SETUP;
						end
					end
					tws_pkg::PH_RELEASE: begin
						phase_d  = tws_pkg::PH_READ;
						idx_d    = '0;
						acc_d[0] = acc_q[0] | data_pin_in;
						sclk_d   = 1'b1;
						step_d   = tws_pkg::STEP_HIGH;
					end
					tws_pkg::PH_READ: begin
						if (step_q == tws_pkg::STEP_HIGH) begin
							sclk_d = 1'b0;
							step_d = tws_pkg::STEP_LOW;
						end else if (idx_q != 3'd7) begin
							idx_d        = idx_q + 3'd1;
							acc_d[idx_d] = acc_q[idx_d] | data_pin_in;
							sclk_d       = 1'b1;
							step_d       = tws_pkg::STEP_HIGH;
						end else begin
							ce_d    = 1'b0;
							phase_d = tws_pkg::PH_DISABLE;
						end
					end
					default: begin
						// end of disable hold: report and return to idle
						res.done_res = 1'b1;
						if (rmode_q) begin
							res.read_byte = acc_q;
						end
						phase_d = tws_pkg::PH_IDLE;
						step_d  = tws_pkg::STEP_SETUP;
						idx_d   = '0;
						dly_d   = dly_q;
					end
				endcase
			end
		end
		res.chip_enable  = ce_d;
		res.serial_clock = sclk_d;
		res.data_out     = dout_d;
		res.data_drive   = drv_d;
	end

	// State registers, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tws_pkg::PH_IDLE;
			step_q  <= tws_pkg::STEP_SETUP;
			idx_q   <= '0;
			dly_q   <= '0;
			cmd_q   <= '0;
			wdat_q  <= '0;
			acc_q   <= '0;
			rmode_q <= 1'b0;
			ce_q    <= 1'b0;
			sclk_q  <= 1'b0;
			dout_q  <= 1'b0;
			drv_q   <= 1'b1;
		end else if (step) begin
			phase_q <= phase_d;
			step_q  <= step_d;
			idx_q   <= idx_d;
			dly_q   <= dly_d;
			cmd_q   <= cmd_d;
			wdat_q  <= wdat_d;
			acc_q   <= acc_d;
			rmode_q <= rmode_d;
			ce_q    <= ce_d;
			sclk_q  <= sclk_d;
			dout_q  <= dout_d;
			drv_q   <= drv_d;
		end
	end

endmodule

// ----- rtl/three_wire_serial_master.sv -----
// ----------------------------------------------------------------------------
// three_wire_serial_master
// Three-wire (enable/clock/data) serial master, LSB first, one tick per input.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  req_type, command, write_data, data_pin_in
// out      output     out_valid / out_stall pin levels, busy, done, read byte, ignored
// cfg      input      cfg_valid / cfg_ready ticks_per_delay
//
// One input transfer per cycle while in_stall is low; its result appears in
// the output register on the next cycle. The rate is set by the sequencer
// state register, which updates on every accepted input. Reset clears the
// control state (data drive is set) and sets the delay to one tick. in_stall
// rises only while a result is held and the output side stalls.
// ----------------------------------------------------------------------------
module three_wire_serial_master (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               req_type,
	input  logic [7:0]               command,
	input  logic [7:0]               write_data,
	input  logic                     data_pin_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     chip_enable,
	output logic                     serial_clock,
	output logic                     data_out,
	output logic                     data_drive,
	output logic                     busy_res,
	output logic                     done_res,
	output logic [7:0]               read_byte,
	output logic                     request_ignored,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [tws_pkg::CFG_W-1:0] cfg_data
);

	logic                        accept;
	logic                        out_valid_q;
	logic [tws_pkg::DELAY_W-1:0] ticks_q;
	tws_pkg::res_t               res_next;
	tws_pkg::res_t               res_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;

	// Delay register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= tws_pkg::DELAY_W'(1);
		end else if (cfg_valid) begin
			ticks_q <= tws_pkg::DELAY_W'(cfg_data);
		end
	end

	tws_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.req_type    (req_type),
		.command     (command),
		.write_data  (write_data),
		.data_pin_in (data_pin_in),
		.ticks       (ticks_q),
		.res         (res_next)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign chip_enable     = res_q.chip_enable;
	assign serial_clock    = res_q.serial_clock;
	assign data_out        = res_q.data_out;
	assign data_drive      = res_q.data_drive;
	assign busy_res        = res_q.busy_res;
	assign done_res        = res_q.done_res;
	assign read_byte       = res_q.read_byte;
	assign request_ignored = res_q.request_ignored;

endmodule

// ----- rtl/tws_checker.sv -----
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks for the three-wire serial master.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tws_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       chip_enable,
	input logic       data_out,
	input logic       data_drive,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_byte
);

	// a finished transfer is always inside a busy tick
	`TWS_ASSERT(a_done_busy, out_valid && done_res, busy_res, "done without busy")
	// a released line drives data_out low
	`TWS_ASSERT(a_released_low, out_valid && !data_drive, !data_out, "data_out set while released")
	// a read byte is only shown with done
	`TWS_ASSERT(a_byte_done, out_valid && read_byte != 8'd0, done_res, "read byte without done")
	// enable is never high on a done tick
	`TWS_ASSERT(a_done_ce_low, out_valid && done_res, !chip_enable, "enable high at done")
	// a held result stays put
	`TWS_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(read_byte), "stalled result changed")

endmodule

bind three_wire_serial_master tws_checker u_tws_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.chip_enable (chip_enable),
	.data_out    (data_out),
	.data_drive  (data_drive),
	.busy_res    (busy_res),
	.done_res    (done_res),
	.read_byte   (read_byte)
);
